@@ rtl/core/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Default sizing of the bitmap
    localparam int MAX_BLOCKS_DEF = 65536;
    localparam int WORD_BITS_DEF  = 32;

    // Field and register widths
    localparam int IDX_W      = 16;
    localparam int TOTAL_W    = 17;
    localparam int START_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int TDATA_W    = 24;

    // Highest block count that still fits a block index
    localparam int INDEX_LIMIT = 65536;

    // Register reset values
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd65536;
    localparam logic [START_W-1:0] START_RESET = 16'd1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_TOTAL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START = 1'b1;

    // Requested operation
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2
    } op_t;

    // Result status
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_MODIFY,
        S_HOLD
    } state_t;

    // One result item
    typedef struct packed {
        logic [IDX_W-1:0] alloc_index;
        status_t          status;
    } result_t;

endpackage

@@ rtl/core/ffba_bitmap_mem.sv @@
// ----------------------------------------------------------------------------
// ffba_bitmap_mem
// Bitmap storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffba_bitmap_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read one word, data valid the next cycle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ffba_free_finder.sv @@
// ----------------------------------------------------------------------------
// ffba_free_finder
// Priority encoder: lowest free bit of a bitmap word within a window mask.
// ----------------------------------------------------------------------------
module ffba_free_finder #(
    parameter int WORD_BITS = 32,
    parameter int POS_W     = 5
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_BITS-1:0] window,
    output logic                 found,
    output logic [POS_W-1:0]     pos
);

    logic [WORD_BITS-1:0] cand;

    // Free bits inside the window are candidates
    assign cand  = ~word & window;
    assign found = |cand;

    // Take the lowest candidate: scan down so the lowest hit wins
    always_comb
    begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pos = POS_W'(i);
            end
        end
    end

endmodule

@@ rtl/core/ffba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer of the allocator: clears the bitmap after reset, then runs one
// item at a time as read-modify-write on the bitmap memory. An allocation
// reads one word per cycle from the search start word up to the last word.
// ----------------------------------------------------------------------------
module ffba_ctrl #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = ffba_pkg::WORD_BITS_DEF,
    parameter int ADDR_W     =
        (((((MAX_BLOCKS < ffba_pkg::INDEX_LIMIT) ? MAX_BLOCKS : ffba_pkg::INDEX_LIMIT)
           + WORD_BITS - 1) / WORD_BITS) > 1) ?
        $clog2((((MAX_BLOCKS < ffba_pkg::INDEX_LIMIT) ? MAX_BLOCKS : ffba_pkg::INDEX_LIMIT)
                + WORD_BITS - 1) / WORD_BITS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request side
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ffba_pkg::op_t                   in_op,
    input  logic [ffba_pkg::IDX_W-1:0]      in_index,
    // Configuration
    input  logic [ffba_pkg::TOTAL_W-1:0]    blk_total,
    input  logic [ffba_pkg::START_W-1:0]    search_start,
    // Result side
    output logic                            res_valid,
    input  logic                            res_ready,
    output ffba_pkg::result_t               res,
    // Bitmap memory
    output logic                            mem_re,
    output logic [ADDR_W-1:0]               mem_raddr,
    input  logic [WORD_BITS-1:0]            mem_rdata,
    output logic                            mem_we,
    output logic [ADDR_W-1:0]               mem_waddr,
    output logic [WORD_BITS-1:0]            mem_wdata
);

    localparam int MAP_BLOCKS = (MAX_BLOCKS < ffba_pkg::INDEX_LIMIT) ?
                                MAX_BLOCKS : ffba_pkg::INDEX_LIMIT;
    localparam int MAP_WORDS  = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W     = $clog2(WORD_BITS);
    localparam logic [ffba_pkg::TOTAL_W-1:0] MAP_TOTAL = ffba_pkg::TOTAL_W'(MAP_BLOCKS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

    ffba_pkg::state_t                 state_reg, state_next;
    ffba_pkg::op_t                    op_reg, op_next;
    logic [ffba_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [ADDR_W-1:0]                cur_reg, cur_next;
    logic [ADDR_W-1:0]                start_word_reg, start_word_next;
    logic [WORD_W-1:0]                start_bit_reg, start_bit_next;
    logic [ADDR_W-1:0]                last_word_reg, last_word_next;
    logic [WORD_W-1:0]                last_bit_reg, last_bit_next;
    logic [ADDR_W-1:0]                clr_reg, clr_next;
    ffba_pkg::result_t                res_reg, res_next;

    logic [ffba_pkg::TOTAL_W-1:0]     total_eff;
    logic [ffba_pkg::START_W-1:0]     start_eff;
    logic [ffba_pkg::IDX_W-1:0]       last_idx;
    logic [WORD_BITS-1:0]             lo_mask;
    logic [WORD_BITS-1:0]             hi_mask;
    logic [WORD_BITS-1:0]             bit_mask;
    logic                             hit;
    logic [WORD_W-1:0]                hit_pos;

    // Clip the block total to the bitmap size; never start below block 1
    assign total_eff = (blk_total > MAP_TOTAL) ? MAP_TOTAL : blk_total;
    assign start_eff = (search_start < ffba_pkg::START_W'(2)) ?
                       ffba_pkg::START_W'(1) : search_start;
    assign last_idx  = ffba_pkg::IDX_W'(total_eff - ffba_pkg::TOTAL_W'(1));

    // Window of the current word that lies inside [start, total)
    assign lo_mask = (cur_reg == start_word_reg) ? ('1 << start_bit_reg) : '1;
    assign hi_mask = (cur_reg == last_word_reg)  ? ('1 >> ~last_bit_reg) : '1;
    assign bit_mask = WORD_BITS'(1) << idx_reg[WORD_W-1:0];

    ffba_free_finder #(
        .WORD_BITS (WORD_BITS),
        .POS_W     (WORD_W)
    ) u_finder (
        .word   (mem_rdata),
        .window (lo_mask & hi_mask),
        .found  (hit),
        .pos    (hit_pos)
    );

    // State and context registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        start_word_reg <= start_word_next;
        start_bit_reg  <= start_bit_next;
        last_word_reg  <= last_word_next;
        last_bit_reg   <= last_bit_next;
        res_reg        <= res_next;
    end

    // Next state, memory access and result
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        start_word_next = start_word_reg;
        start_bit_next  = start_bit_reg;
        last_word_next  = last_word_reg;
        last_bit_next   = last_bit_reg;
        clr_next        = clr_reg;
        res_next        = res_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = cur_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_wdata       = mem_rdata;

        case (state_reg)
            ffba_pkg::S_CLEAR:
            begin
                // Zero one word per cycle
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = ffba_pkg::S_IDLE;
                end
            end

            ffba_pkg::S_IDLE:
            begin
                // Take the next item
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_op;
                    idx_next   = in_index;
                    state_next = ffba_pkg::S_START;
                end
            end

            ffba_pkg::S_START:
            begin
                res_next.alloc_index = '0;
                res_next.status      = ffba_pkg::ST_DONE;
                case (op_reg)
                    ffba_pkg::OP_ALLOC:
                    begin
                        start_word_next = ADDR_W'(start_eff >> WORD_W);
                        start_bit_next  = start_eff[WORD_W-1:0];
                        last_word_next  = ADDR_W'(last_idx >> WORD_W);
                        last_bit_next   = last_idx[WORD_W-1:0];
                        if ({1'b0, start_eff} >= total_eff)
                        begin
                            res_next.status = ffba_pkg::ST_NO_FREE;
                            state_next      = ffba_pkg::S_HOLD;
                        end
                        else
                        begin
                            // Fetch the first word of the scan
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(start_eff >> WORD_W);
                            cur_next   = ADDR_W'(start_eff >> WORD_W);
                            state_next = ffba_pkg::S_SCAN;
                        end
                    end
                    ffba_pkg::OP_FREE, ffba_pkg::OP_MARK:
                    begin
                        if ({1'b0, idx_reg} >= total_eff)
                        begin
                            res_next.status = ffba_pkg::ST_IGNORED;
                            state_next      = ffba_pkg::S_HOLD;
                        end
                        else
                        begin
                            // Fetch the word holding the block
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(idx_reg >> WORD_W);
                            cur_next   = ADDR_W'(idx_reg >> WORD_W);
                            state_next = ffba_pkg::S_MODIFY;
                        end
                    end
                    default:
                    begin
                        res_next.status = ffba_pkg::ST_IGNORED;
                        state_next      = ffba_pkg::S_HOLD;
                    end
                endcase
            end

            ffba_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    // Claim the block and report its index
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | (WORD_BITS'(1) << hit_pos);
                    res_next.alloc_index = ffba_pkg::IDX_W'({cur_reg, hit_pos});
                    res_next.status      = ffba_pkg::ST_DONE;
                    state_next           = ffba_pkg::S_HOLD;
                end
                else if (cur_reg == last_word_reg)
                begin
                    res_next.alloc_index = '0;
                    res_next.status      = ffba_pkg::ST_NO_FREE;
                    state_next           = ffba_pkg::S_HOLD;
                end
                else
                begin
                    // Advance to the next word
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg + ADDR_W'(1);
                    cur_next  = cur_reg + ADDR_W'(1);
                end
            end

            ffba_pkg::S_MODIFY:
            begin
                // Set or clear the block bit and write the word back
                mem_we = 1'b1;
                if (op_reg == ffba_pkg::OP_MARK)
                begin
                    mem_wdata = mem_rdata | bit_mask;
                end
                else
                begin
                    mem_wdata = mem_rdata & ~bit_mask;
                end
                state_next = ffba_pkg::S_HOLD;
            end

            ffba_pkg::S_HOLD:
            begin
                // Hand the result over when the output slot is free
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

`ifndef NO_ASSERTIONS
    // The bitmap is written only while clearing or finishing an item
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ffba_pkg::S_CLEAR || state_reg == ffba_pkg::S_SCAN ||
                    state_reg == ffba_pkg::S_MODIFY))
        else $error("bitmap written outside a write phase");

    // An accepted item is decoded in the following cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ffba_pkg::S_START)
        else $error("accepted item not decoded");

    // A successful allocation never returns block 0
    a_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && op_reg == ffba_pkg::OP_ALLOC && res.status == ffba_pkg::ST_DONE)
        |-> res.alloc_index != '0)
        else $error("allocation returned block 0");

    // Only allocations report an index
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && op_reg != ffba_pkg::OP_ALLOC) |-> res.alloc_index == '0)
        else $error("index reported for a non-allocating item");

    // The scan never runs past the last managed word
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffba_pkg::S_SCAN |-> cur_reg <= last_word_reg)
        else $error("scan beyond last word");
`endif

endmodule

@@ rtl/core/first_fit_block_bitmap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_bitmap_allocator_unit
// Block allocator over a used/free bitmap with first-fit search.
// ----------------------------------------------------------------------------
// After reset the unit clears its bitmap memory one word per cycle and takes
// no item while it clears; configuration writes are taken during that time.
// Items are handled one at a time as read-modify-write on the bitmap memory:
// a free or a mark reads the word that holds the block and writes it back,
// while an ignored request, or an allocation whose search start is at or
// beyond the total, is answered without a memory access. Any other
// allocation reads one bitmap word per cycle from the word holding the
// search start until a free block is found or the block total is reached
// (up to 2048 words at the defaults). A finished result waits in an output
// register and the next item is accepted while it waits; a second finished
// result then holds the input off until the output register drains.
// ----------------------------------------------------------------------------
module first_fit_block_bitmap_allocator_unit #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = ffba_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffba_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ffba_pkg::TDATA_W-1:0]      s_tdata,  // [1:0] operation, [17:2] block number
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ffba_pkg::TDATA_W-1:0]      m_tdata   // [1:0] status, [17:2] allocated_index
);

    localparam int MAP_BLOCKS = (MAX_BLOCKS < ffba_pkg::INDEX_LIMIT) ?
                                MAX_BLOCKS : ffba_pkg::INDEX_LIMIT;
    localparam int MAP_WORDS  = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [ffba_pkg::TOTAL_W-1:0] blk_total_reg;
    logic [ffba_pkg::START_W-1:0] search_start_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    ffba_pkg::result_t            out_reg, out_next;

    logic                         res_valid;
    logic                         res_ready;
    ffba_pkg::result_t            res;

    logic                         mem_re;
    logic [ADDR_W-1:0]            mem_raddr;
    logic [WORD_BITS-1:0]         mem_rdata;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [WORD_BITS-1:0]         mem_wdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_total_reg    <= ffba_pkg::TOTAL_RESET;
            search_start_reg <= ffba_pkg::START_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffba_pkg::CFG_BLK_TOTAL: blk_total_reg <= cfg_data;
                ffba_pkg::CFG_SEARCH_START:
                    search_start_reg <= cfg_data[ffba_pkg::START_W-1:0];
                default: ;
            endcase
        end
    end

    ffba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (ffba_pkg::op_t'(s_tdata[1:0])),
        .in_index     (s_tdata[17:2]),
        .blk_total    (blk_total_reg),
        .search_start (search_start_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata)
    );

    ffba_bitmap_mem #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: load a result when the slot is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reg.alloc_index, out_reg.status};

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block bitmap allocator unit.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the register extremes, every
// operation, block 0, the top block, repeated free and mark, the unknown
// operation and the out-of-range cases. Random request segments follow, each
// under its own total/start setting. A local bitmap predicts each result that
// the table does not give; results are compared field by field in arrival order.
// Traffic runs with a slow receiver, then a slow sender, then full rate with
// one long receiver hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb;

    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 6;
    localparam int          SEGMENTS      = 6;
    localparam int          SEG_ITEMS     = 250;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES  = 50;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PRINT_LIMIT   = 20;
    localparam int unsigned CYCLE_LIMIT   = 2000000;

    // The block answers this code with an ignored status
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef enum logic [1:0] {
        TRAFFIC_RX_SLOW,
        TRAFFIC_TX_SLOW,
        TRAFFIC_FULL
    } traffic_mode_t;

    // One line of the directed table
    typedef struct packed {
        row_kind_t                        kind;
        logic [1:0]                       op;
        logic [ffba_pkg::CFG_DATA_W-1:0]  value;
        logic [ffba_pkg::CFG_IDX_W-1:0]   reg_sel;
        logic                             typed;
        ffba_pkg::result_t                outcome;
    } directed_row_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [ffba_pkg::TDATA_W-1:0]     s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [ffba_pkg::TDATA_W-1:0]     m_tdata;

    // Local copy of the allocator state
    bit                               block_used [ffba_pkg::MAX_BLOCKS_DEF];
    logic [ffba_pkg::TOTAL_W-1:0]     model_total = ffba_pkg::TOTAL_RESET;
    logic [ffba_pkg::START_W-1:0]     model_start = ffba_pkg::START_RESET;

    ffba_pkg::result_t                pending_results [$];
    directed_row_t                    directed_rows [$];

    traffic_mode_t          traffic_mode  = TRAFFIC_RX_SLOW;
    bit                     hold_request  = 1'b0;
    int                     hold_left     = 0;
    int unsigned            cycle_count   = 0;
    int                     mismatch_count = 0;
    int                     sent_count    = 0;
    int                     checked_count = 0;
    int                     alloc_done    = 0;
    int                     alloc_failed  = 0;
    int                     ignored_count = 0;
    int                     config_writes = 0;

    first_fit_block_bitmap_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [1:0] operation, [17:2] block number
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // [1:0] status, [17:2] allocated_index
    );

    always #HALF_PERIOD clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit sender_gap();
        case (traffic_mode)
            TRAFFIC_RX_SLOW: return $urandom_range(0, 99) < 18;
            TRAFFIC_TX_SLOW: return $urandom_range(0, 99) < 74;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (traffic_mode)
            TRAFFIC_RX_SLOW: return $urandom_range(0, 99) < 74;
            TRAFFIC_TX_SLOW: return $urandom_range(0, 99) < 18;
            default:         return 1'b0;
        endcase
    endfunction

    // Apply one request to the local bitmap and return its result
    function automatic ffba_pkg::result_t predict_allocation(
        input logic [1:0] op, input logic [ffba_pkg::IDX_W-1:0] idx);
        int unsigned       limit;
        int unsigned       blk;
        ffba_pkg::result_t res;
        limit = 32'(model_total);
        if (limit > ffba_pkg::MAX_BLOCKS_DEF)
            limit = ffba_pkg::MAX_BLOCKS_DEF;
        if (limit > ffba_pkg::INDEX_LIMIT)
            limit = ffba_pkg::INDEX_LIMIT;
        res.status      = ffba_pkg::ST_DONE;
        res.alloc_index = '0;
        if (op == ffba_pkg::OP_ALLOC)
        begin
            res.status = ffba_pkg::ST_NO_FREE;
            blk = (model_start > 16'd1) ? 32'(model_start) : 32'd1;
            for (; blk < limit; blk++)
            begin
                if (!block_used[blk])
                begin
                    block_used[blk] = 1'b1;
                    res.status      = ffba_pkg::ST_DONE;
                    res.alloc_index = blk[ffba_pkg::IDX_W-1:0];
                    break;
                end
            end
        end
        else if (op == ffba_pkg::OP_FREE || op == ffba_pkg::OP_MARK)
        begin
            if (32'(idx) >= limit)
                res.status = ffba_pkg::ST_IGNORED;
            else
                block_used[idx] = (op == ffba_pkg::OP_MARK);
        end
        else
        begin
            res.status = ffba_pkg::ST_IGNORED;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [ffba_pkg::TDATA_W-1:0] got,
                                   input logic [ffba_pkg::TDATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at result %0d (cycle %0d): %s got %0h want %0h",
                     checked_count, cycle_count, what, got, want);
    endtask

    // Offer one item, wait for acceptance, then queue its expected result
    task automatic issue_request(input logic [1:0] op,
                                 input logic [ffba_pkg::IDX_W-1:0] idx,
                                 input logic typed,
                                 input ffba_pkg::result_t typed_result);
        ffba_pkg::result_t predicted;
        while (sender_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ffba_pkg::TDATA_W-ffba_pkg::IDX_W-2){1'b0}}, idx, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_allocation(op, idx);
        pending_results.push_back(typed ? typed_result : predicted);
        sent_count++;
    endtask

    // Write a register once the unit has gone quiet
    task automatic write_register(input logic [ffba_pkg::CFG_IDX_W-1:0] sel,
                                  input logic [ffba_pkg::CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (sel == ffba_pkg::CFG_BLK_TOTAL)
            model_total = value[ffba_pkg::TOTAL_W-1:0];
        else
            model_start = value[ffba_pkg::START_W-1:0];
        config_writes++;
    endtask

    task automatic add_item(input logic [1:0] op, input logic [ffba_pkg::IDX_W-1:0] idx,
                            input logic typed, input ffba_pkg::status_t st,
                            input logic [ffba_pkg::IDX_W-1:0] alloc_idx);
        directed_row_t row;
        row.kind                = ROW_ITEM;
        row.op                  = op;
        row.value               = {1'b0, idx};
        row.reg_sel             = ffba_pkg::CFG_BLK_TOTAL;
        row.typed               = typed;
        row.outcome.status      = st;
        row.outcome.alloc_index = alloc_idx;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [ffba_pkg::CFG_IDX_W-1:0] sel,
                           input logic [ffba_pkg::CFG_DATA_W-1:0] value);
        directed_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_sel = sel;
        row.value   = value;
        directed_rows.push_back(row);
    endtask

    // Drive ready, with the long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !receiver_gap();
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        ffba_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", ffba_pkg::TDATA_W'(m_tdata[1:0]),
                                    ffba_pkg::TDATA_W'(want.status));
                if (m_tdata[17:2] !== want.alloc_index)
                    report_mismatch("allocated_index", ffba_pkg::TDATA_W'(m_tdata[17:2]),
                                    ffba_pkg::TDATA_W'(want.alloc_index));
                if (m_tdata[ffba_pkg::TDATA_W-1:18] !== '0)
                    report_mismatch("padding",
                                    ffba_pkg::TDATA_W'(m_tdata[ffba_pkg::TDATA_W-1:18]), '0);
                case (want.status)
                    ffba_pkg::ST_DONE:    if (m_tdata[17:2] != 0) alloc_done++;
                    ffba_pkg::ST_NO_FREE: alloc_failed++;
                    default:              ignored_count++;
                endcase
            end
            checked_count++;
        end
    end

    initial
    begin
        directed_row_t                row;
        logic [1:0]                   op;
        logic [ffba_pkg::IDX_W-1:0]   idx;
        int                           pick;
        int unsigned                  total_sel;
        int unsigned                  start_sel;
        int unsigned                  win_lo;
        int unsigned                  win_hi;
        int                           random_sent;

        // Directed table: fresh bitmap under reset settings
        add_item(ffba_pkg::OP_ALLOC, 16'd0,    1'b1, ffba_pkg::ST_DONE,    16'd1);
        add_item(ffba_pkg::OP_ALLOC, 16'd0,    1'b1, ffba_pkg::ST_DONE,    16'd2);
        add_item(ffba_pkg::OP_FREE,  16'd1,    1'b1, ffba_pkg::ST_DONE,    16'd0);
        add_item(ffba_pkg::OP_ALLOC, 16'd0,    1'b1, ffba_pkg::ST_DONE,    16'd1);
        add_item(ffba_pkg::OP_FREE,  16'd0,    1'b1, ffba_pkg::ST_DONE,    16'd0);
        add_item(ffba_pkg::OP_MARK,  16'hFFFF, 1'b1, ffba_pkg::ST_DONE,    16'd0);
        add_item(ffba_pkg::OP_FREE,  16'hFFFF, 1'b1, ffba_pkg::ST_DONE,    16'd0);
        // repeated free and repeated mark
        add_item(ffba_pkg::OP_FREE,  16'hFFFF, 1'b1, ffba_pkg::ST_DONE,    16'd0);
        add_item(ffba_pkg::OP_MARK,  16'd2,    1'b1, ffba_pkg::ST_DONE,    16'd0);
        add_item(OP_UNKNOWN,         16'd0,    1'b1, ffba_pkg::ST_IGNORED, 16'd0);
        add_item(OP_UNKNOWN,         16'hFFFF, 1'b1, ffba_pkg::ST_IGNORED, 16'd0);
        // allocate ignores the index field
        add_item(ffba_pkg::OP_ALLOC, 16'hFFFF, 1'b1, ffba_pkg::ST_DONE,    16'd3);
        // small total, start below one: out-of-range requests, then fill up
        add_cfg(ffba_pkg::CFG_BLK_TOTAL, 17'd10);
        add_cfg(ffba_pkg::CFG_SEARCH_START, 17'd0);
        add_item(ffba_pkg::OP_FREE,  16'd12,   1'b1, ffba_pkg::ST_IGNORED, 16'd0);
        add_item(ffba_pkg::OP_MARK,  16'd10,   1'b1, ffba_pkg::ST_IGNORED, 16'd0);
        add_item(ffba_pkg::OP_MARK,  16'd9,    1'b1, ffba_pkg::ST_DONE,    16'd0);
        repeat (6) add_item(ffba_pkg::OP_ALLOC, 16'd0, 1'b0, ffba_pkg::ST_DONE, 16'd0);
        // zero blocks managed
        add_cfg(ffba_pkg::CFG_BLK_TOTAL, 17'd0);
        add_item(ffba_pkg::OP_ALLOC, 16'd0,    1'b1, ffba_pkg::ST_NO_FREE, 16'd0);
        add_item(ffba_pkg::OP_FREE,  16'd0,    1'b1, ffba_pkg::ST_IGNORED, 16'd0);
        // oversized total clamps; start at the top block
        add_cfg(ffba_pkg::CFG_BLK_TOTAL, 17'h1FFFF);
        add_cfg(ffba_pkg::CFG_SEARCH_START, 17'd65535);
        add_item(ffba_pkg::OP_ALLOC, 16'd0,    1'b1, ffba_pkg::ST_DONE,    16'd65535);
        add_item(ffba_pkg::OP_ALLOC, 16'd0,    1'b1, ffba_pkg::ST_NO_FREE, 16'd0);
        add_cfg(ffba_pkg::CFG_SEARCH_START, 17'd0);
        add_item(ffba_pkg::OP_ALLOC, 16'd0,    1'b0, ffba_pkg::ST_DONE,    16'd0);

        // Hold reset, then release
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_register(row.reg_sel, row.value);
            else
                issue_request(row.op, row.value[ffba_pkg::IDX_W-1:0], row.typed,
                              row.outcome);
        end

        // Random segments, each under its own setting
        random_sent = 0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 3)
                0:
                begin
                    total_sel = $urandom_range(40, 300);
                    start_sel = $urandom_range(0, 8);
                    win_lo    = 0;
                    win_hi    = total_sel + 8;
                end
                1:
                begin
                    total_sel = $urandom_range(64, 2000);
                    // one segment starts the search at or past the total
                    if (seg == 4)
                        start_sel = total_sel + $urandom_range(0, 20);
                    else
                        start_sel = $urandom_range(0, total_sel / 2);
                    win_lo    = 0;
                    win_hi    = total_sel + 8;
                end
                default:
                begin
                    total_sel = (seg == 2) ? 65536 : 17'h1FFFF;
                    start_sel = $urandom_range(65280, 65535);
                    win_lo    = 65200;
                    win_hi    = 65535;
                end
            endcase
            write_register(ffba_pkg::CFG_BLK_TOTAL, total_sel[ffba_pkg::CFG_DATA_W-1:0]);
            write_register(ffba_pkg::CFG_SEARCH_START,
                           {1'b0, start_sel[ffba_pkg::START_W-1:0]});

            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // advance the traffic pattern by thirds, hold off once
                if (random_sent == SEGMENTS * SEG_ITEMS / 3)
                    traffic_mode = TRAFFIC_TX_SLOW;
                if (random_sent == 2 * SEGMENTS * SEG_ITEMS / 3)
                begin
                    traffic_mode = TRAFFIC_FULL;
                    hold_request = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = ffba_pkg::OP_ALLOC;
                else if (pick < 75)
                    op = ffba_pkg::OP_FREE;
                else if (pick < 94)
                    op = ffba_pkg::OP_MARK;
                else
                    op = OP_UNKNOWN;
                if ($urandom_range(0, 9) == 0)
                    idx = ffba_pkg::IDX_W'($urandom_range(0, 65535));
                else
                    idx = ffba_pkg::IDX_W'($urandom_range(win_lo,
                                           (win_hi > 65535) ? 65535 : win_hi));
                issue_request(op, idx, 1'b0, '0);
                random_sent++;
            end
        end

        // Drain and finish
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests and checked %0d results over %0d register writes",
                 sent_count, checked_count, config_writes);
        $display("allocated %0d blocks, %0d searches found none, %0d requests ignored",
                 alloc_done, alloc_failed, ignored_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ffba_pkg.sv
rtl/core/ffba_bitmap_mem.sv
rtl/core/ffba_free_finder.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_bitmap_allocator_unit.sv
sim/tb.sv
